// File: hw/rtl/voxel_octree_store_assert.svh
// Assertion macros shared by the voxel octree store
`ifndef VOXEL_OCTREE_STORE_ASSERT_SVH
`define VOXEL_OCTREE_STORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define VOS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define VOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vos_pkg.sv
// Types and constants of the voxel octree store
package vos_pkg;

    localparam int LEVELS     = 4;
    localparam int COORD_BITS = 4;
    localparam int VALUE_BITS = 16;
    localparam int LVL_BITS   = 3;
    localparam int SH_BITS    = 2;
    localparam int NODE_COUNT = ((1 << (3 * (LEVELS + 1))) - 1) / 7;
    localparam int IDX_BITS   = $clog2(NODE_COUNT);

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
        logic [COORD_BITS-1:0] z_coord;
        logic [VALUE_BITS-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] voxel_value;
        logic [LVL_BITS-1:0]   leaf_level;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LRD,
        ST_LCHK,
        ST_SPLIT_W,
        ST_SPLIT_P,
        ST_LEAF_W,
        ST_MRD,
        ST_MCHK,
        ST_MW,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CHILD,
        WR_INNER,
        WR_LEAF,
        WR_MERGE
    } wr_kind_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_NODE,
        RD_SIB
    } rd_kind_t;

    typedef struct packed {
        logic     load;
        rd_kind_t rd;
        wr_kind_t wr;
        logic     descend;
        logic     ascend;
        logic     save_cur;
        logic     k_inc;
        logic     res_load;
        logic     res_from_mem;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic inner_node;
        logic match_v;
        logic lvl_full;
        logic lvl_last;
        logic lvl_one;
        logic is_write;
        logic k_last;
        logic sib_ok;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/vos_store.sv
// Node store: root held in flops, all other nodes in a single-port style memory
module vos_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [vos_pkg::IDX_BITS-1:0]   raddr,
    input  logic                           wr_en,
    input  logic [vos_pkg::IDX_BITS-1:0]   waddr,
    input  logic [vos_pkg::VALUE_BITS-1:0] wval,
    input  logic                           whc,
    output logic [vos_pkg::VALUE_BITS-1:0] rval,
    output logic                           rhc
);

    logic [vos_pkg::VALUE_BITS-1:0] val_mem [vos_pkg::NODE_COUNT];
    logic                           hc_mem  [vos_pkg::NODE_COUNT];
    logic [vos_pkg::VALUE_BITS-1:0] root_val_reg;
    logic                           root_hc_reg;
    logic [vos_pkg::VALUE_BITS-1:0] rval_reg;
    logic                           rhc_reg;

    // Hold the root node, which starts as an empty leaf
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_val_reg <= '0;
            root_hc_reg  <= 1'b0;
        end
        else if (wr_en && waddr == '0)
        begin
            root_val_reg <= wval;
            root_hc_reg  <= whc;
        end
    end

    // Write the node memory
    always_ff @(posedge clk)
    begin
        if (wr_en && waddr != '0)
        begin
            val_mem[waddr] <= wval;
            hc_mem[waddr]  <= whc;
        end
    end

    // Register the read beat
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (raddr == '0)
            begin
                rval_reg <= root_val_reg;
                rhc_reg  <= root_hc_reg;
            end
            else
            begin
                rval_reg <= val_mem[raddr];
                rhc_reg  <= hc_mem[raddr];
            end
        end
    end

    assign rval = rval_reg;
    assign rhc  = rhc_reg;

endmodule

// File: hw/rtl/vos_ctrl.sv
// Controller state machine of the voxel octree store
module vos_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            busy,
    input  vos_pkg::sts_t   sts,
    output vos_pkg::cmd_t   cmd
);

    vos_pkg::state_t state_reg;
    vos_pkg::state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= vos_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vos_pkg::ST_IDLE:
                if (req_valid)
                    state_next = vos_pkg::ST_LRD;
            vos_pkg::ST_LRD:
                state_next = vos_pkg::ST_LCHK;
            vos_pkg::ST_LCHK:
            begin
                if (sts.inner_node && !sts.lvl_full)
                    state_next = vos_pkg::ST_LRD;
                else if (!sts.is_write || sts.match_v)
                    state_next = vos_pkg::ST_DONE;
                else if (sts.lvl_full)
                    state_next = vos_pkg::ST_LEAF_W;
                else
                    state_next = vos_pkg::ST_SPLIT_W;
            end
            vos_pkg::ST_SPLIT_W:
                if (sts.k_last)
                    state_next = vos_pkg::ST_SPLIT_P;
            vos_pkg::ST_SPLIT_P:
                state_next = sts.lvl_last ? vos_pkg::ST_LEAF_W : vos_pkg::ST_SPLIT_W;
            vos_pkg::ST_LEAF_W:
                state_next = vos_pkg::ST_MRD;
            vos_pkg::ST_MRD:
                state_next = vos_pkg::ST_MCHK;
            vos_pkg::ST_MCHK:
            begin
                if (!sts.sib_ok)
                    state_next = vos_pkg::ST_DONE;
                else if (sts.k_last)
                    state_next = vos_pkg::ST_MW;
                else
                    state_next = vos_pkg::ST_MRD;
            end
            vos_pkg::ST_MW:
                state_next = sts.lvl_one ? vos_pkg::ST_DONE : vos_pkg::ST_MRD;
            vos_pkg::ST_DONE:
                if (sts.out_free)
                    state_next = vos_pkg::ST_IDLE;
            default:
                state_next = vos_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd = '0;
        cmd.rd = vos_pkg::RD_NONE;
        cmd.wr = vos_pkg::WR_NONE;
        case (state_reg)
            vos_pkg::ST_IDLE:
                cmd.load = req_valid;
            vos_pkg::ST_LRD:
                cmd.rd = vos_pkg::RD_NODE;
            vos_pkg::ST_LCHK:
            begin
                if (sts.inner_node && !sts.lvl_full)
                    cmd.descend = 1'b1;
                else if (!sts.is_write || sts.match_v)
                begin
                    cmd.res_load     = 1'b1;
                    cmd.res_from_mem = 1'b1;
                end
                else
                    cmd.save_cur = 1'b1;
            end
            vos_pkg::ST_SPLIT_W:
            begin
                cmd.wr    = vos_pkg::WR_CHILD;
                cmd.k_inc = 1'b1;
            end
            vos_pkg::ST_SPLIT_P:
            begin
                cmd.wr      = vos_pkg::WR_INNER;
                cmd.descend = 1'b1;
            end
            vos_pkg::ST_LEAF_W:
            begin
                cmd.wr       = vos_pkg::WR_LEAF;
                cmd.res_load = 1'b1;
            end
            vos_pkg::ST_MRD:
                cmd.rd = vos_pkg::RD_SIB;
            vos_pkg::ST_MCHK:
                cmd.k_inc = sts.sib_ok && !sts.k_last;
            vos_pkg::ST_MW:
            begin
                cmd.wr     = vos_pkg::WR_MERGE;
                cmd.ascend = 1'b1;
            end
            vos_pkg::ST_DONE:
                cmd.emit = sts.out_free;
            default:
                cmd.load = 1'b0;
        endcase
    end

    assign busy = (state_reg != vos_pkg::ST_IDLE);

endmodule

// File: hw/rtl/vos_dp.sv
// Datapath: walk position, node addressing and the result register
module vos_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vos_pkg::req_t                  req,
    input  vos_pkg::cmd_t                  cmd,
    output vos_pkg::sts_t                  sts,
    input  logic                           rsp_stall,
    output logic                           rsp_valid,
    output vos_pkg::rsp_t                  rsp,
    output logic                           rd_en,
    output logic [vos_pkg::IDX_BITS-1:0]   raddr,
    output logic                           wr_en,
    output logic [vos_pkg::IDX_BITS-1:0]   waddr,
    output logic [vos_pkg::VALUE_BITS-1:0] wval,
    output logic                           whc,
    input  logic [vos_pkg::VALUE_BITS-1:0] rval,
    input  logic                           rhc
);

    localparam int IB = vos_pkg::IDX_BITS;
    localparam int LB = vos_pkg::LVL_BITS;

    vos_pkg::req_t                  req_reg;
    logic [IB-1:0]                  idx_reg;
    logic [LB-1:0]                  lvl_reg;
    logic [2:0]                     k_reg;
    logic [vos_pkg::VALUE_BITS-1:0] cur_reg;
    logic [vos_pkg::VALUE_BITS-1:0] res_val_reg;
    logic                           rsp_valid_reg;
    vos_pkg::rsp_t                  rsp_reg;

    logic [LB-1:0]      sh_w;
    logic [vos_pkg::SH_BITS-1:0] sh;
    logic [2:0]         csel;
    logic [IB-1:0]      kids;
    logic [IB-1:0]      child;
    logic [IB-1:0]      idx_m1;
    logic [IB-1:0]      parent;
    logic [IB-1:0]      sib;

    // Pick the child octant at the current level
    assign sh_w   = LB'(vos_pkg::LEVELS - 1) - lvl_reg;
    assign sh     = sh_w[vos_pkg::SH_BITS-1:0];
    assign csel   = {req_reg.x_coord[sh], req_reg.y_coord[sh], req_reg.z_coord[sh]};
    assign kids   = {idx_reg[IB-4:0], 3'b000} + IB'(1);
    assign child  = kids + IB'(csel);
    assign idx_m1 = idx_reg - IB'(1);
    assign parent = {3'b000, idx_m1[IB-1:3]};
    assign sib    = {idx_m1[IB-1:3], 3'b000} + IB'(1) + IB'(k_reg);

    // Drive the node store
    always_comb
    begin
        rd_en = (cmd.rd != vos_pkg::RD_NONE);
        raddr = (cmd.rd == vos_pkg::RD_SIB) ? sib : idx_reg;
        wr_en = (cmd.wr != vos_pkg::WR_NONE);
        waddr = idx_reg;
        wval  = req_reg.write_value;
        whc   = 1'b0;
        case (cmd.wr)
            vos_pkg::WR_CHILD:
            begin
                waddr = kids + IB'(k_reg);
                wval  = cur_reg;
            end
            vos_pkg::WR_INNER:
            begin
                wval = '0;
                whc  = 1'b1;
            end
            vos_pkg::WR_MERGE:
                waddr = parent;
            default:
                waddr = idx_reg;
        endcase
    end

    // Hold the item and advance the walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            idx_reg <= '0;
            lvl_reg <= '0;
            k_reg   <= '0;
        end
        else
        begin
            if (cmd.descend)
            begin
                idx_reg <= child;
                lvl_reg <= lvl_reg + LB'(1);
            end
            else if (cmd.ascend)
            begin
                idx_reg <= parent;
                lvl_reg <= lvl_reg - LB'(1);
                k_reg   <= '0;
            end
            if (cmd.k_inc)
                k_reg <= k_reg + 3'd1;
        end
        if (cmd.save_cur)
        begin
            cur_reg <= rval;
            k_reg   <= '0;
        end
        if (cmd.res_load)
            res_val_reg <= cmd.res_from_mem ? rval : req_reg.write_value;
        if (cmd.emit)
            rsp_reg <= '{voxel_value: res_val_reg, leaf_level: lvl_reg};
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    // Status to the controller
    always_comb
    begin
        sts.inner_node   = rhc;
        sts.match_v      = (rval == req_reg.write_value);
        sts.lvl_full     = (lvl_reg == LB'(vos_pkg::LEVELS));
        sts.lvl_last     = (lvl_reg == LB'(vos_pkg::LEVELS - 1));
        sts.lvl_one      = (lvl_reg == LB'(1));
        sts.is_write     = (req_reg.mode == vos_pkg::MODE_WRITE);
        sts.k_last       = (k_reg == 3'd7);
        sts.sib_ok       = (rval == req_reg.write_value) && !rhc;
        sts.out_free     = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hw/rtl/voxel_octree_store.sv
// Voxel octree store: a 16x16x16 volume held as a complete octree in a node array.
// One request at a time. A read reads and then checks each node from the root down, then
// loads the result beat. A write walks down the same way; a write that reaches a coarse
// leaf then splits it level by level (8 child writes and the parent at each level) and
// writes the leaf. Every write that changes a leaf then reads and checks the siblings and
// merges them upward, over up to four levels. These steps share the node memory's single
// read and write port. The result beat sits in an output register, so the next request
// is taken in the cycle after the result is loaded there.
module voxel_octree_store (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  vos_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output vos_pkg::rsp_t  rsp
);

`include "voxel_octree_store_assert.svh"

    vos_pkg::cmd_t                  cmd;
    vos_pkg::sts_t                  sts;
    logic                           busy;
    logic                           rd_en;
    logic [vos_pkg::IDX_BITS-1:0]   raddr;
    logic                           wr_en;
    logic [vos_pkg::IDX_BITS-1:0]   waddr;
    logic [vos_pkg::VALUE_BITS-1:0] wval;
    logic                           whc;
    logic [vos_pkg::VALUE_BITS-1:0] rval;
    logic                           rhc;

    vos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .busy      (busy),
        .sts       (sts),
        .cmd       (cmd)
    );

    vos_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rd_en     (rd_en),
        .raddr     (raddr),
        .wr_en     (wr_en),
        .waddr     (waddr),
        .wval      (wval),
        .whc       (whc),
        .rval      (rval),
        .rhc       (rhc)
    );

    vos_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (rd_en),
        .raddr (raddr),
        .wr_en (wr_en),
        .waddr (waddr),
        .wval  (wval),
        .whc   (whc),
        .rval  (rval),
        .rhc   (rhc)
    );

    assign req_stall = busy;

    `VOS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "idle after accept")
    `VOS_ASSERT_SAME(a_level_range, rsp_valid, rsp.leaf_level <= 3'd4, "leaf level out of range")
    `VOS_ASSERT_SAME(a_no_read_write_clash, rd_en && wr_en, 1'b0, "store read and write together")

endmodule

// File: sim/tb.sv
// Self-checking testbench of the voxel octree store
module tb;

    localparam int DEPTH     = 4;
    localparam int NODES     = 4681;
    localparam int RAND_BEATS = 1030;
    localparam int WATCHDOG  = 4000;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    vos_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    vos_pkg::rsp_t rsp;

    voxel_octree_store dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // Predicted octree
    logic [vos_pkg::VALUE_BITS-1:0] tree_value [NODES];
    logic                           tree_split [NODES];

    vos_pkg::rsp_t pending_rsp[$];
    int   faults;
    int   idle_cycles;
    bit   stim_done;

    // Directed table: mode, x, y, z, value, typed expectation flag, expected value, level
    typedef struct {
        logic        mode;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  z;
        logic [15:0] v;
        bit          typed;
        logic [15:0] ev;
        logic [2:0]  el;
    } row_t;

    row_t rows[$];
    bit   typed_q[$];
    vos_pkg::rsp_t typed_rsp_q[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int child_of(int idx, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                    int lvl);
        int sh;
        sh = DEPTH - 1 - lvl;
        return idx * 8 + 1 + ((int'(x[sh]) << 2) | (int'(y[sh]) << 1) | int'(z[sh]));
    endfunction

    // Descend to the leaf covering the point
    function automatic int find_leaf(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                     output int lvl);
        int idx;
        idx = 0;
        lvl = 0;
        while (lvl < DEPTH && tree_split[idx])
        begin
            idx = child_of(idx, x, y, z, lvl);
            lvl++;
        end
        return idx;
    endfunction

    // Apply one beat to the predicted tree and return the result
    function automatic vos_pkg::rsp_t octree_apply(vos_pkg::req_t r);
        int   lvl;
        int   idx;
        int   par;
        int   base;
        bit   same;
        vos_pkg::rsp_t res;
        idx = find_leaf(r.x_coord, r.y_coord, r.z_coord, lvl);
        if (r.mode == vos_pkg::MODE_WRITE && tree_value[idx] != r.write_value)
        begin
            if (lvl >= DEPTH)
            begin
                tree_value[idx] = r.write_value;
                // merge equal childless siblings upward
                while (idx > 0)
                begin
                    par  = (idx - 1) / 8;
                    base = par * 8 + 1;
                    same = 1'b1;
                    for (int i = 0; i < 8; i++)
                        if (tree_value[base + i] != tree_value[base] || tree_split[base + i])
                            same = 1'b0;
                    if (!same)
                        break;
                    tree_split[par] = 1'b0;
                    tree_value[par] = tree_value[base];
                    idx = par;
                end
            end
            else
            begin
                while (lvl < DEPTH)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        tree_value[idx * 8 + 1 + i] = tree_value[idx];
                        tree_split[idx * 8 + 1 + i] = 1'b0;
                    end
                    tree_split[idx] = 1'b1;
                    tree_value[idx] = '0;
                    idx = child_of(idx, r.x_coord, r.y_coord, r.z_coord, lvl);
                    lvl++;
                end
                tree_value[idx] = r.write_value;
            end
        end
        idx = find_leaf(r.x_coord, r.y_coord, r.z_coord, lvl);
        res.voxel_value = tree_value[idx];
        res.leaf_level  = lvl[vos_pkg::LVL_BITS-1:0];
        return res;
    endfunction

    task automatic report_fault(string what, logic [31:0] got, logic [31:0] want);
        $display("beat fault: %s got %0h want %0h", what, got, want);
        faults++;
    endtask

    task automatic send_beat(vos_pkg::req_t r, bit typed, vos_pkg::rsp_t want);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // idle the request side for the drawn gap
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        // accepted: predict now, before any result can return
        pending_rsp.insert(pending_rsp.size(), octree_apply(r));
        typed_q.insert(typed_q.size(), typed);
        typed_rsp_q.insert(typed_rsp_q.size(), want);
        @(negedge clk);
    endtask

    function automatic vos_pkg::req_t random_beat();
        vos_pkg::req_t r;
        int   pick;
        r.mode = $urandom_range(0, 2) != 0 ? vos_pkg::MODE_WRITE : vos_pkg::MODE_READ;
        pick = $urandom_range(0, 9);
        // keep most beats inside a small region so merges and splits happen often
        if (pick < 6)
        begin
            r.x_coord = 4'($urandom_range(0, 3)) | 4'(($urandom_range(0, 1)) << 3);
            r.y_coord = 4'($urandom_range(0, 3));
            r.z_coord = 4'($urandom_range(0, 3)) | 4'(($urandom_range(0, 1)) << 2);
        end
        else
        begin
            r.x_coord = 4'($urandom);
            r.y_coord = 4'($urandom);
            r.z_coord = 4'($urandom);
        end
        case ($urandom_range(0, 4))
            0: r.write_value = 16'($urandom);
            1: r.write_value = 16'hFFFF;
            default: r.write_value = 16'($urandom_range(0, 2));
        endcase
        return r;
    endfunction

    // Stimulus
    initial
    begin
        vos_pkg::req_t r;
        vos_pkg::rsp_t want;
        faults    = 0;
        stim_done = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        for (int i = 0; i < NODES; i++)
        begin
            tree_value[i] = '0;
            tree_split[i] = 1'b0;
        end
        rows = '{
            '{1'b0, 4'h0, 4'h0, 4'h0, 16'h0000, 1, 16'h0000, 3'd0},
            '{1'b0, 4'hF, 4'hF, 4'hF, 16'hFFFF, 1, 16'h0000, 3'd0},
            '{1'b1, 4'h0, 4'h0, 4'h0, 16'h0000, 1, 16'h0000, 3'd0},
            '{1'b1, 4'hF, 4'hF, 4'hF, 16'hFFFF, 1, 16'hFFFF, 3'd4},
            '{1'b0, 4'hF, 4'hF, 4'hE, 16'h1234, 1, 16'h0000, 3'd4},
            '{1'b0, 4'h0, 4'h0, 4'h0, 16'h0000, 1, 16'h0000, 3'd1},
            '{1'b1, 4'hF, 4'hF, 4'hF, 16'h0000, 1, 16'h0000, 3'd0},
            '{1'b1, 4'h0, 4'h0, 4'h0, 16'h8001, 1, 16'h8001, 3'd4},
            '{1'b1, 4'h0, 4'h0, 4'h1, 16'h8001, 0, 16'h0, 3'd0},
            '{1'b1, 4'h0, 4'h1, 4'h0, 16'h8001, 0, 16'h0, 3'd0},
            '{1'b1, 4'h0, 4'h1, 4'h1, 16'h8001, 0, 16'h0, 3'd0},
            '{1'b1, 4'h1, 4'h0, 4'h0, 16'h8001, 0, 16'h0, 3'd0},
            '{1'b1, 4'h1, 4'h0, 4'h1, 16'h8001, 0, 16'h0, 3'd0},
            '{1'b1, 4'h1, 4'h1, 4'h0, 16'h8001, 0, 16'h0, 3'd0},
            '{1'b1, 4'h1, 4'h1, 4'h1, 16'h8001, 1, 16'h8001, 3'd3},
            '{1'b0, 4'h1, 4'h0, 4'h1, 16'h5555, 1, 16'h8001, 3'd3},
            '{1'b1, 4'h1, 4'h0, 4'h1, 16'h8001, 1, 16'h8001, 3'd3},
            '{1'b1, 4'h8, 4'h4, 4'h2, 16'hAAAA, 0, 16'h0, 3'd0},
            '{1'b1, 4'h7, 4'hB, 4'hD, 16'h5555, 0, 16'h0, 3'd0},
            '{1'b0, 4'h8, 4'h4, 4'h2, 16'h0000, 1, 16'hAAAA, 3'd4}
        };
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        foreach (rows[i])
        begin
            r.mode        = rows[i].mode;
            r.x_coord     = rows[i].x;
            r.y_coord     = rows[i].y;
            r.z_coord     = rows[i].z;
            r.write_value = rows[i].v;
            want.voxel_value = rows[i].ev;
            want.leaf_level  = rows[i].el;
            send_beat(r, rows[i].typed, want);
        end

        // random beats
        for (int n = 0; n < RAND_BEATS; n++)
            send_beat(random_beat(), 1'b0, '0);
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side stall
    initial
    begin
        int hold;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
            // hold the stall for the drawn number of cycles
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // Check result beats against the prediction, or against the table's expectation for typed rows
    always @(posedge clk)
    begin
        vos_pkg::rsp_t want;
        vos_pkg::rsp_t typed_want;
        bit   typed;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report_fault("unexpected result", 32'(rsp), '0);
            else
            begin
                want       = pending_rsp[0];
                typed      = typed_q[0];
                typed_want = typed_rsp_q[0];
                pending_rsp.delete(0);
                typed_q.delete(0);
                typed_rsp_q.delete(0);
                if (typed)
                    want = typed_want;
                if (rsp.voxel_value !== want.voxel_value)
                    report_fault("voxel_value", 32'(rsp.voxel_value), 32'(want.voxel_value));
                if (rsp.leaf_level !== want.leaf_level)
                    report_fault("leaf_level", 32'(rsp.leaf_level), 32'(want.leaf_level));
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("voxel_octree_store: mismatch");
            $finish;
        end
    end

    // End of run
    initial
    begin
        idle_cycles = 0;
        wait (stim_done);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (faults == 0)
            $display("voxel_octree_store: match");
        else
            $display("voxel_octree_store: mismatch");
        $finish;
    end

endmodule
